/* design/sca_pkg.sv */
// Shared types and constants of the slab class allocator.
// Used by sca_ctrl, sca_dp and slab_class_allocator; depends on nothing.
`default_nettype none
package sca_pkg;

    localparam int CLASS_COUNT_DEF = 64;
    localparam int FREE_DEPTH_DEF  = 256;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int LIMIT_W  = 32;
    localparam int GROWTH_W = 19;
    localparam int SMALL_W  = 13;
    localparam int CHUNK_W  = 18;
    localparam int CPS_W    = 15;   // slab_bytes / 8 reaches 32767
    localparam int RUN_W    = 20;
    localparam int ROUND_W  = 21;
    localparam int SIZE_W   = 32;
    localparam int CADDR_W  = 32;
    localparam int CLS_W    = 6;
    localparam int STAT_W   = 3;
    localparam int DIV_STEPS = 18;
    localparam int DIVC_W   = 5;

    localparam logic [GROWTH_W-1:0] GROWTH_RST = 19'd81920;
    localparam logic [SMALL_W-1:0]  SMALL_RST  = 13'd16;
    localparam logic [CHUNK_W-1:0]  SLAB_RST   = 18'd131072;
    localparam logic [RUN_W-1:0]    ALIGN_MIN  = 20'd8;

    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_ALLOC  = 2'd2;
    localparam logic [1:0] REQ_FREE   = 2'd3;

    localparam logic [1:0] CFG_MEM_LIMIT = 2'd0;
    localparam logic [1:0] CFG_GROWTH    = 2'd1;
    localparam logic [1:0] CFG_SMALLEST  = 2'd2;
    localparam logic [1:0] CFG_SLAB      = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_CLASS = 3'd3;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd4;
    localparam logic [STAT_W-1:0] ST_STACK_FULL = 3'd5;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INIT_ROUND, S_INIT_DIV, S_INIT_WRITE,
        S_LK_READ, S_LK_CMP, S_AF_READ, S_AF_EVAL, S_POP, S_CARVE, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DECODE, OP_ROUND, OP_DIV_STEP, OP_INIT_WRITE,
        OP_LK_READ, OP_LK_CMP, OP_AF_READ, OP_AF_EVAL, OP_POP, OP_CARVE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       quick_fail;
        logic       round_last;
        logic       div_last;
        logic       init_end;
        logic       lk_done;
        logic       af_pop;
        logic       af_carve;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

/* design/sca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* design/sca_ctrl.sv */
// Controller state machine: sequences each request and drives datapath commands.
// Depends on sca_pkg.
`default_nettype none
module sca_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sca_pkg::t_stat i_stat,
    output sca_pkg::t_cmd       o_cmd
);
    sca_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = sca_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            sca_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = sca_pkg::OP_LOAD;
                    n_state  = sca_pkg::S_DECODE;
                end
            end
            sca_pkg::S_DECODE: begin
                o_cmd.op = sca_pkg::OP_DECODE;
                if (i_stat.req_type == sca_pkg::REQ_INIT) begin
                    n_state = sca_pkg::S_INIT_ROUND;
                end else if (i_stat.quick_fail) begin
                    n_state = sca_pkg::S_DONE;
                end else if (i_stat.req_type == sca_pkg::REQ_LOOKUP) begin
                    n_state = sca_pkg::S_LK_READ;
                end else begin
                    n_state = sca_pkg::S_AF_READ;
                end
            end
            sca_pkg::S_INIT_ROUND: begin
                o_cmd.op = sca_pkg::OP_ROUND;
                n_state  = i_stat.round_last ? sca_pkg::S_INIT_WRITE : sca_pkg::S_INIT_DIV;
            end
            sca_pkg::S_INIT_DIV: begin
                o_cmd.op = sca_pkg::OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = sca_pkg::S_INIT_WRITE;
                end
            end
            sca_pkg::S_INIT_WRITE: begin
                o_cmd.op = sca_pkg::OP_INIT_WRITE;
                n_state  = i_stat.init_end ? sca_pkg::S_DONE : sca_pkg::S_INIT_ROUND;
            end
            sca_pkg::S_LK_READ: begin
                o_cmd.op = sca_pkg::OP_LK_READ;
                n_state  = sca_pkg::S_LK_CMP;
            end
            sca_pkg::S_LK_CMP: begin
                o_cmd.op = sca_pkg::OP_LK_CMP;
                n_state  = i_stat.lk_done ? sca_pkg::S_DONE : sca_pkg::S_LK_READ;
            end
            sca_pkg::S_AF_READ: begin
                o_cmd.op = sca_pkg::OP_AF_READ;
                n_state  = sca_pkg::S_AF_EVAL;
            end
            sca_pkg::S_AF_EVAL: begin
                o_cmd.op = sca_pkg::OP_AF_EVAL;
                if (i_stat.af_pop) begin
                    n_state = sca_pkg::S_POP;
                end else if (i_stat.af_carve) begin
                    n_state = sca_pkg::S_CARVE;
                end else begin
                    n_state = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_POP: begin
                o_cmd.op = sca_pkg::OP_POP;
                n_state  = sca_pkg::S_DONE;
            end
            sca_pkg::S_CARVE: begin
                o_cmd.op = sca_pkg::OP_CARVE;
                n_state  = sca_pkg::S_DONE;
            end
            sca_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sca_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* design/sca_dp.sv */
// Datapath: config registers, class table, per-class state, free stacks,
// divider for chunks per slab, pool bookkeeping and the output register.
// Depends on sca_pkg and sca_ram.
`default_nettype none
module sca_dp #(
    parameter int CLASS_COUNT = sca_pkg::CLASS_COUNT_DEF,
    parameter int FREE_DEPTH  = sca_pkg::FREE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = sca_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sca_pkg::t_cmd                 i_cmd,
    output sca_pkg::t_stat                     o_stat,
    input  wire logic                          i_cfg_valid,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [sca_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [sca_pkg::SIZE_W-1:0]    i_req_size,
    input  wire logic [sca_pkg::CLS_W-1:0]     i_class_index,
    input  wire logic [sca_pkg::CADDR_W-1:0]   i_chunk_address,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [sca_pkg::STAT_W-1:0]         o_status,
    output logic [sca_pkg::CLS_W-1:0]          o_class,
    output logic [sca_pkg::CADDR_W-1:0]        o_address,
    output logic [sca_pkg::CHUNK_W-1:0]        o_chunk_size
);
    localparam int CIW   = (CLASS_COUNT > 2) ? $clog2(CLASS_COUNT) : 1;
    localparam int CMW   = (CIW > sca_pkg::CLS_W) ? CIW : sca_pkg::CLS_W;
    localparam int FCW   = $clog2(FREE_DEPTH + 1);
    localparam int SD    = CLASS_COUNT * FREE_DEPTH;
    localparam int SAW   = $clog2(SD);
    localparam int PW    = ADDR_WIDTH + 1;
    localparam int LEN_W = sca_pkg::CHUNK_W + sca_pkg::CPS_W;
    localparam int SUM_W = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int TW    = sca_pkg::CHUNK_W + sca_pkg::CPS_W;
    localparam int SWW   = 1 + sca_pkg::CPS_W + ADDR_WIDTH + FCW;
    localparam int MW    = 17 + sca_pkg::GROWTH_W;

    // configuration
    logic [sca_pkg::LIMIT_W-1:0]  r_limit;
    logic [sca_pkg::GROWTH_W-1:0] r_gf;
    logic [sca_pkg::SMALL_W-1:0]  r_small;
    logic [sca_pkg::CHUNK_W-1:0]  r_slab;

    // request
    logic [1:0]                   r_type;
    logic [sca_pkg::SIZE_W-1:0]   r_rsize;
    logic [sca_pkg::CLS_W-1:0]    r_cls;
    logic [sca_pkg::CADDR_W-1:0]  r_ain;

    // table build and walk
    logic                         r_table_ready;
    logic [CIW-1:0]               r_top;
    logic [CIW-1:0]               r_idx;
    logic [sca_pkg::RUN_W-1:0]    r_run;
    logic [sca_pkg::ROUND_W-1:0]  r_round;
    logic                         r_last;
    logic [sca_pkg::CHUNK_W-1:0]  r_div_rem;
    logic [sca_pkg::CHUNK_W-1:0]  r_div_num;
    logic [sca_pkg::CHUNK_W-1:0]  r_div_q;
    logic [sca_pkg::DIVC_W-1:0]   r_div_cnt;

    // per-class state, pool
    logic [CLASS_COUNT-1:0]       r_valid;
    logic [PW-1:0]                r_pool;
    logic [FCW-1:0]               r_cnt;
    logic [ADDR_WIDTH-1:0]        r_ptr;
    logic [sca_pkg::CPS_W-1:0]    r_left;
    logic                         r_has;
    logic [sca_pkg::CHUNK_W-1:0]  r_chunk;
    logic [sca_pkg::CPS_W-1:0]    r_cps;
    logic [LEN_W-1:0]             r_len;

    // result and output
    logic [sca_pkg::STAT_W-1:0]   r_res_status;
    logic [sca_pkg::CLS_W-1:0]    r_res_class;
    logic [sca_pkg::CADDR_W-1:0]  r_res_addr;
    logic [sca_pkg::CHUNK_W-1:0]  r_res_size;
    logic                         r_out_valid;
    logic [sca_pkg::STAT_W-1:0]   r_out_status;
    logic [sca_pkg::CLS_W-1:0]    r_out_class;
    logic [sca_pkg::CADDR_W-1:0]  r_out_addr;
    logic [sca_pkg::CHUNK_W-1:0]  r_out_size;

    // class index handling
    logic [CMW-1:0] cls_ext, top_ext, idx_ext;
    logic [CIW-1:0] cls_idx;
    logic           quick_fail;

    assign cls_ext = CMW'(r_cls);
    assign top_ext = CMW'(r_top);
    assign idx_ext = CMW'(r_idx);
    assign cls_idx = cls_ext[CIW-1:0];

    always_comb begin
        case (r_type)
            sca_pkg::REQ_INIT:   quick_fail = 1'b0;
            sca_pkg::REQ_LOOKUP: quick_fail = (r_rsize == '0) || !r_table_ready;
            default:             quick_fail = !r_table_ready || (cls_ext > top_ext);
        endcase
    end

    // rounding, divider and growth
    logic [sca_pkg::RUN_W-1:0]   run_min;
    logic [sca_pkg::ROUND_W-1:0] round_c;
    logic                        round_last_c;
    logic [sca_pkg::CHUNK_W-1:0] div_sh, div_d;
    logic                        div_ge;
    logic                        div_last;
    logic [MW-1:0]               grow_prod;
    logic [sca_pkg::CHUNK_W-1:0] new_chunk;
    logic [sca_pkg::CPS_W-1:0]   new_cps;
    logic                        init_end;

    assign run_min      = (r_run < sca_pkg::ALIGN_MIN) ? sca_pkg::ALIGN_MIN : r_run;
    assign round_c      = (sca_pkg::ROUND_W'(run_min) + sca_pkg::ROUND_W'(7))
                          & ~sca_pkg::ROUND_W'(7);
    // last class once a chunk fits at most once in a slab
    assign round_last_c = ({round_c, 1'b0} > (sca_pkg::ROUND_W + 1)'(r_slab));

    assign div_sh   = {r_div_rem[sca_pkg::CHUNK_W-2:0], r_div_num[sca_pkg::CHUNK_W-1]};
    assign div_d    = sca_pkg::CHUNK_W'(r_round[16:0]);
    assign div_ge   = (div_sh >= div_d);
    assign div_last = (r_div_cnt == sca_pkg::DIVC_W'(sca_pkg::DIV_STEPS - 1));

    assign grow_prod = MW'(r_round[16:0]) * MW'(r_gf);
    assign new_chunk = r_last ? r_slab : r_round[sca_pkg::CHUNK_W-1:0];
    assign new_cps   = r_last ? sca_pkg::CPS_W'(1) : r_div_q[sca_pkg::CPS_W-1:0];
    assign init_end  = r_last || (r_idx == CIW'(CLASS_COUNT - 1));

    // class table: {chunk size, chunks per slab}
    logic           tb_re;
    logic [CIW-1:0] tb_raddr;
    logic [TW-1:0]  tb_rdata;
    logic [sca_pkg::CHUNK_W-1:0] tb_chunk;
    logic [sca_pkg::CPS_W-1:0]   tb_cps;

    assign tb_re    = (i_cmd.op == sca_pkg::OP_LK_READ) || (i_cmd.op == sca_pkg::OP_AF_READ);
    assign tb_raddr = (i_cmd.op == sca_pkg::OP_LK_READ) ? r_idx : cls_idx;
    assign tb_chunk = tb_rdata[TW-1:sca_pkg::CPS_W];
    assign tb_cps   = tb_rdata[sca_pkg::CPS_W-1:0];

    sca_ram #(.WIDTH(TW), .DEPTH(CLASS_COUNT)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == sca_pkg::OP_INIT_WRITE),
        .i_waddr (r_idx),
        .i_wdata ({new_chunk, new_cps}),
        .i_re    (tb_re),
        .i_raddr (tb_raddr),
        .o_rdata (tb_rdata)
    );

    // class state: {has slab, carve left, carve pointer, free count}
    logic [SWW-1:0]              cs_rdata, cs_word, cs_wdata;
    logic                        cs_we;
    logic [FCW-1:0]              rd_cnt;
    logic [ADDR_WIDTH-1:0]       rd_ptr;
    logic [sca_pkg::CPS_W-1:0]   rd_left;
    logic                        rd_has;

    assign cs_word = r_valid[cls_idx] ? cs_rdata : '0;
    assign {rd_has, rd_left, rd_ptr, rd_cnt} = cs_word;

    sca_ram #(.WIDTH(SWW), .DEPTH(CLASS_COUNT)) u_class_state (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cls_idx),
        .i_wdata (cs_wdata),
        .i_re    (i_cmd.op == sca_pkg::OP_AF_READ),
        .i_raddr (cls_idx),
        .o_rdata (cs_rdata)
    );

    // free stacks, one region of FREE_DEPTH entries per class
    logic [SAW-1:0]              fs_base, fs_waddr, fs_raddr;
    logic [sca_pkg::CADDR_W-1:0] fs_rdata;
    logic                        is_alloc, is_free, stack_full, free_ok, pop_go;

    assign fs_base    = SAW'(cls_idx) * SAW'(FREE_DEPTH);
    assign fs_waddr   = fs_base + SAW'(rd_cnt);
    assign fs_raddr   = fs_base + SAW'(rd_cnt - FCW'(1));
    assign is_alloc   = (r_type == sca_pkg::REQ_ALLOC);
    assign is_free    = (r_type == sca_pkg::REQ_FREE);
    assign stack_full = (rd_cnt >= FCW'(FREE_DEPTH));
    assign free_ok    = (i_cmd.op == sca_pkg::OP_AF_EVAL) && is_free && !stack_full;
    assign pop_go     = (i_cmd.op == sca_pkg::OP_AF_EVAL) && is_alloc && (rd_cnt != '0);

    sca_ram #(.WIDTH(sca_pkg::CADDR_W), .DEPTH(SD)) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (free_ok),
        .i_waddr (fs_waddr),
        .i_wdata (r_ain),
        .i_re    (pop_go),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    // carving a chunk, taking a new slab first when the current one is used up
    logic [SUM_W-1:0]            pool_sum;
    logic                        need_slab, limit_hit, over, carve_ok;
    logic [ADDR_WIDTH-1:0]       ptr_eff;
    logic [sca_pkg::CPS_W-1:0]   left_eff;
    logic [63:0]                 addr_wide;

    assign pool_sum  = SUM_W'(r_pool) + SUM_W'(r_len);
    assign need_slab = (r_left == '0);
    // a class's first slab ignores the memory limit
    assign limit_hit = (r_limit != '0) && (pool_sum > SUM_W'(r_limit)) && r_has;
    assign over      = pool_sum > (SUM_W'(1) << ADDR_WIDTH);
    assign carve_ok  = !need_slab || (!limit_hit && !over);
    assign ptr_eff   = need_slab ? r_pool[ADDR_WIDTH-1:0] : r_ptr;
    assign left_eff  = need_slab ? r_cps : r_left;
    assign addr_wide = 64'(ptr_eff);

    always_comb begin
        cs_we    = 1'b0;
        cs_wdata = cs_word;
        if (pop_go) begin
            cs_we    = 1'b1;
            cs_wdata = {rd_has, rd_left, rd_ptr, rd_cnt - FCW'(1)};
        end else if (free_ok) begin
            cs_we    = 1'b1;
            cs_wdata = {rd_has, rd_left, rd_ptr, rd_cnt + FCW'(1)};
        end else if ((i_cmd.op == sca_pkg::OP_CARVE) && carve_ok) begin
            cs_we    = 1'b1;
            cs_wdata = {1'b1, left_eff - sca_pkg::CPS_W'(1),
                        ptr_eff + ADDR_WIDTH'(r_chunk), r_cnt};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= '0;
            r_gf          <= sca_pkg::GROWTH_RST;
            r_small       <= sca_pkg::SMALL_RST;
            r_slab        <= sca_pkg::SLAB_RST;
            r_table_ready <= 1'b0;
            r_top         <= '0;
            r_valid       <= '0;
            r_pool        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sca_pkg::CFG_MEM_LIMIT: r_limit <= i_cfg_data;
                    sca_pkg::CFG_GROWTH:    r_gf    <= i_cfg_data[sca_pkg::GROWTH_W-1:0];
                    sca_pkg::CFG_SMALLEST:  r_small <= i_cfg_data[sca_pkg::SMALL_W-1:0];
                    sca_pkg::CFG_SLAB:      r_slab  <= i_cfg_data[sca_pkg::CHUNK_W-1:0];
                    default: ;
                endcase
            end
            if ((i_cmd.op == sca_pkg::OP_DECODE) && (r_type == sca_pkg::REQ_INIT)) begin
                r_valid <= '0;
                r_pool  <= '0;
            end
            if (i_cmd.op == sca_pkg::OP_INIT_WRITE) begin
                r_top <= r_idx;
                if (init_end) begin
                    r_table_ready <= 1'b1;
                end
            end
            if (cs_we) begin
                r_valid[cls_idx] <= 1'b1;
            end
            if ((i_cmd.op == sca_pkg::OP_CARVE) && need_slab && carve_ok) begin
                r_pool <= pool_sum[PW-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sca_pkg::OP_LOAD: begin
                r_type  <= i_req_type;
                r_rsize <= i_req_size;
                r_cls   <= i_class_index;
                r_ain   <= i_chunk_address;
            end
            sca_pkg::OP_DECODE: begin
                r_res_class <= '0;
                r_res_addr  <= '0;
                r_res_size  <= '0;
                r_idx       <= '0;
                r_run       <= sca_pkg::RUN_W'(r_small);
                case (r_type)
                    sca_pkg::REQ_INIT:   r_res_status <= sca_pkg::ST_OK;
                    sca_pkg::REQ_LOOKUP: r_res_status <= (r_rsize == '0) ?
                                             sca_pkg::ST_ZERO_SIZE : sca_pkg::ST_NO_FIT;
                    default:             r_res_status <= quick_fail ?
                                             sca_pkg::ST_BAD_CLASS : sca_pkg::ST_OK;
                endcase
            end
            sca_pkg::OP_ROUND: begin
                r_round   <= round_c;
                r_last    <= round_last_c;
                r_div_rem <= '0;
                r_div_num <= r_slab;
                r_div_q   <= '0;
                r_div_cnt <= '0;
            end
            sca_pkg::OP_DIV_STEP: begin
                r_div_rem <= div_ge ? (div_sh - div_d) : div_sh;
                r_div_num <= {r_div_num[sca_pkg::CHUNK_W-2:0], 1'b0};
                r_div_q   <= {r_div_q[sca_pkg::CHUNK_W-2:0], div_ge};
                r_div_cnt <= r_div_cnt + sca_pkg::DIVC_W'(1);
            end
            sca_pkg::OP_INIT_WRITE: begin
                if (init_end) begin
                    r_res_class <= idx_ext[sca_pkg::CLS_W-1:0];
                    r_res_size  <= new_chunk;
                end else begin
                    r_run <= grow_prod[MW-1:16];
                    r_idx <= r_idx + CIW'(1);
                end
            end
            sca_pkg::OP_LK_CMP: begin
                if (r_rsize <= sca_pkg::SIZE_W'(tb_chunk)) begin
                    r_res_status <= sca_pkg::ST_OK;
                    r_res_class  <= idx_ext[sca_pkg::CLS_W-1:0];
                    r_res_size   <= tb_chunk;
                end else begin
                    r_idx <= r_idx + CIW'(1);
                end
            end
            sca_pkg::OP_AF_EVAL: begin
                r_res_class <= r_cls;
                r_res_size  <= tb_chunk;
                r_cnt       <= rd_cnt;
                r_ptr       <= rd_ptr;
                r_left      <= rd_left;
                r_has       <= rd_has;
                r_chunk     <= tb_chunk;
                r_cps       <= tb_cps;
                r_len       <= LEN_W'(tb_chunk) * LEN_W'(tb_cps);
                if (is_free && stack_full) begin
                    r_res_status <= sca_pkg::ST_STACK_FULL;
                end
            end
            sca_pkg::OP_POP: begin
                r_res_addr <= fs_rdata;
            end
            sca_pkg::OP_CARVE: begin
                if (carve_ok) begin
                    r_res_addr <= addr_wide[sca_pkg::CADDR_W-1:0];
                end else if (limit_hit) begin
                    r_res_status <= sca_pkg::ST_LIMIT;
                end else begin
                    r_res_status <= sca_pkg::ST_OVERFLOW;
                end
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_class  <= r_res_class;
            r_out_addr   <= r_res_addr;
            r_out_size   <= r_res_size;
        end
    end

    assign o_stat.req_type   = r_type;
    assign o_stat.quick_fail = quick_fail;
    assign o_stat.round_last = round_last_c;
    assign o_stat.div_last   = div_last;
    assign o_stat.init_end   = init_end;
    assign o_stat.lk_done    = (r_rsize <= sca_pkg::SIZE_W'(tb_chunk)) || (r_idx == r_top);
    assign o_stat.af_pop     = is_alloc && (rd_cnt != '0);
    assign o_stat.af_carve   = is_alloc && (rd_cnt == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_class      = r_out_class;
    assign o_address    = r_out_addr;
    assign o_chunk_size = r_out_size;
endmodule
`default_nettype wire

/* design/slab_class_allocator.sv */
// Slab allocator with size classes: top level joining controller and datapath.
// Depends on sca_pkg, sca_ctrl, sca_dp (and sca_ram through sca_dp).
//
// Requests arrive on the s_axis channel, one at a time; tuser carries the
// request kind (init, lookup, allocate, free), tdata the operands. Each
// request gives exactly one response on m_axis. The config channel is always
// ready and writes memory_limit, growth_factor, smallest_chunk, slab_bytes
// by index 0..3; write it only while no request is in flight.
// Each request steps through its states in turn: allocate reads the class
//   state and then pops its free stack or carves, free pushes onto its stack,
//   a rejected request goes straight to the response, lookup reads and
//   compares one class after another, init rounds each class size and then
//   divides (an 18-step radix-2 divider computes chunks per slab for each
//   class but a closing whole-slab class).
// The next request is taken in the cycle after the response is loaded.
// The response sits in an output register; while the receiver stalls, the
// next request may already be taken and worked on, but its result waits
// for the register to drain. Reset clears config to defaults, marks the
// class table as unbuilt and empties all free stacks, slabs and the pool.
`default_nettype none
module slab_class_allocator #(
    parameter int CLASS_COUNT = sca_pkg::CLASS_COUNT_DEF,
    parameter int FREE_DEPTH  = sca_pkg::FREE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = sca_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // req_size[31:0], class_index[37:32],
                                            // chunk_address[69:38], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // status[2:0], class_out[8:3],
                                            // address_out[40:9], chunk_size_out[58:41]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    sca_pkg::t_cmd  cmd;
    sca_pkg::t_stat stat;

    logic [sca_pkg::STAT_W-1:0]  out_status;
    logic [sca_pkg::CLS_W-1:0]   out_class;
    logic [sca_pkg::CADDR_W-1:0] out_addr;
    logic [sca_pkg::CHUNK_W-1:0] out_size;

    assign o_cfg_ready = 1'b1;

    sca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sca_dp #(
        .CLASS_COUNT (CLASS_COUNT),
        .FREE_DEPTH  (FREE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (s_axis_tuser),
        .i_req_size      (s_axis_tdata[31:0]),
        .i_class_index   (s_axis_tdata[37:32]),
        .i_chunk_address (s_axis_tdata[69:38]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (out_status),
        .o_class         (out_class),
        .o_address       (out_addr),
        .o_chunk_size    (out_size)
    );

    assign m_axis_tdata = {5'd0, out_size, out_addr, out_class, out_status};
endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for slab_class_allocator: request stream in, response stream out.
// Depends on sca_pkg and the design sources; keeps its own copy of the allocator state.
module tb;
    localparam int NCLS       = sca_pkg::CLASS_COUNT_DEF;
    localparam int STACK_D    = sca_pkg::FREE_DEPTH_DEF;
    localparam int CYCLE_CAP  = 10000000;

    typedef struct {
        bit [2:0]  status;
        bit [5:0]  cls;
        bit [31:0] addr;
        bit [17:0] chunk;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    slab_class_allocator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the allocator
    bit [31:0] lim_reg = 0;
    bit [18:0] growth_reg = sca_pkg::GROWTH_RST;
    bit [12:0] small_reg = sca_pkg::SMALL_RST;
    bit [17:0] slab_reg = sca_pkg::SLAB_RST;
    bit [17:0] chunk_tbl [NCLS];
    bit [14:0] per_slab [NCLS];
    int unsigned top_cls = 0;
    bit        built = 0;
    bit [31:0] stack_mem [NCLS][STACK_D];
    int unsigned stack_cnt [NCLS];
    longint unsigned carve_ptr [NCLS];
    int unsigned carve_rem [NCLS];
    bit        slab_taken [NCLS];
    longint unsigned pool_bytes = 0;

    reply_t    pending_q [$];
    int        errors = 0;
    int        replies = 0;
    int        requests = 0;
    int        status_seen [8];
    longint    cycles = 0;
    bit        no_idle = 0;
    int        rdy_hold = 0;

    function automatic void empty_pool();
        for (int i = 0; i < NCLS; i++) begin
            stack_cnt[i] = 0;
            carve_ptr[i] = 0;
            carve_rem[i] = 0;
            slab_taken[i] = 0;
        end
        pool_bytes = 0;
    endfunction

    function automatic void build_classes();
        longint unsigned sz;
        sz = small_reg;
        empty_pool();
        top_cls = 0;
        for (int i = 0; i < NCLS; i++) begin
            if (sz < 8) sz = 8;
            if (sz % 8 != 0) sz += 8 - sz % 8;
            top_cls = i;
            if (sz > slab_reg || slab_reg / sz <= 1) begin
                chunk_tbl[i] = slab_reg;
                per_slab[i] = 1;
                break;
            end
            chunk_tbl[i] = sz;
            per_slab[i] = slab_reg / sz;
            sz = (sz * growth_reg) >> 16;
        end
        built = 1;
    endfunction

    function automatic reply_t serve_request(logic [1:0] kind, bit [31:0] size,
                                             bit [5:0] cls, bit [31:0] addr_in);
        reply_t r;
        longint unsigned len;
        r = '{sca_pkg::ST_OK, 0, 0, 0};
        if (kind == sca_pkg::REQ_INIT) begin
            build_classes();
            r.cls = top_cls;
            r.chunk = chunk_tbl[top_cls];
        end else if (kind == sca_pkg::REQ_LOOKUP) begin
            if (size == 0) r.status = sca_pkg::ST_ZERO_SIZE;
            else begin
                r.status = sca_pkg::ST_NO_FIT;
                if (built)
                    for (int i = 0; i <= top_cls; i++)
                        if (size <= chunk_tbl[i]) begin
                            r.status = sca_pkg::ST_OK;
                            r.cls = i;
                            r.chunk = chunk_tbl[i];
                            break;
                        end
            end
        end else if (!built || cls > top_cls) begin
            r.status = sca_pkg::ST_BAD_CLASS;
        end else begin
            r.cls = cls;
            r.chunk = chunk_tbl[cls];
            if (kind == sca_pkg::REQ_ALLOC) begin
                if (stack_cnt[cls] != 0) begin
                    stack_cnt[cls]--;
                    r.addr = stack_mem[cls][stack_cnt[cls]];
                end else begin
                    if (carve_rem[cls] == 0) begin
                        len = longint'(chunk_tbl[cls]) * per_slab[cls];
                        if (lim_reg != 0 && pool_bytes + len > lim_reg && slab_taken[cls])
                            r.status = sca_pkg::ST_LIMIT;
                        else if (pool_bytes + len > (64'd1 << sca_pkg::ADDR_WIDTH_DEF))
                            r.status = sca_pkg::ST_OVERFLOW;
                        else begin
                            carve_ptr[cls] = pool_bytes;
                            carve_rem[cls] = per_slab[cls];
                            slab_taken[cls] = 1;
                            pool_bytes += len;
                        end
                    end
                    if (r.status == sca_pkg::ST_OK) begin
                        r.addr = carve_ptr[cls][31:0];
                        carve_rem[cls]--;
                        carve_ptr[cls] += chunk_tbl[cls];
                    end
                end
            end else begin
                if (stack_cnt[cls] >= STACK_D) r.status = sca_pkg::ST_STACK_FULL;
                else begin
                    stack_mem[cls][stack_cnt[cls]] = addr_in;
                    stack_cnt[cls]++;
                end
            end
        end
        return r;
    endfunction

    task automatic report(string what, bit [31:0] got, bit [31:0] want);
        errors++;
        $display("MISMATCH response %0d %s: got %0h expected %0h", replies, what, got, want);
    endtask

    // response checker
    always @(posedge i_clk) begin
        reply_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies++;
            status_seen[m_axis_tdata[2:0]]++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("MISMATCH response %0d arrived with nothing outstanding", replies);
            end else begin
                w = pending_q.pop_front();
                if (m_axis_tdata[2:0] != w.status) report("status", m_axis_tdata[2:0], w.status);
                if (m_axis_tdata[8:3] != w.cls) report("class", m_axis_tdata[8:3], w.cls);
                if (m_axis_tdata[40:9] != w.addr) report("address", m_axis_tdata[40:9], w.addr);
                if (m_axis_tdata[58:41] != w.chunk) report("chunk", m_axis_tdata[58:41], w.chunk);
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rdy_hold = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("slab_class_allocator verification failed");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] kind, bit [31:0] size, bit [5:0] cls,
                                bit [31:0] addr_in);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b0, addr_in, cls, size};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(serve_request(kind, size, cls, addr_in));
        requests++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            sca_pkg::CFG_MEM_LIMIT: lim_reg = val;
            sca_pkg::CFG_GROWTH:    growth_reg = val[18:0];
            sca_pkg::CFG_SMALLEST:  small_reg = val[12:0];
            default:                slab_reg = val[17:0];
        endcase
    endtask

    task automatic setup(bit [31:0] lim, bit [31:0] gf, bit [31:0] sm, bit [31:0] sb);
        drain();
        write_reg(sca_pkg::CFG_MEM_LIMIT, lim);
        write_reg(sca_pkg::CFG_GROWTH, gf);
        write_reg(sca_pkg::CFG_SMALLEST, sm);
        write_reg(sca_pkg::CFG_SLAB, sb);
        @(posedge i_clk);
        send_request(sca_pkg::REQ_INIT, $urandom, $urandom, $urandom);
    endtask

    task automatic random_request();
        logic [1:0] kind;
        bit [31:0] size;
        bit [5:0]  cls;
        int        pick;
        pick = $urandom_range(0, 99);
        kind = pick < 2 ? sca_pkg::REQ_INIT : pick < 30 ? sca_pkg::REQ_LOOKUP :
               pick < 68 ? sca_pkg::REQ_ALLOC : sca_pkg::REQ_FREE;
        cls = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, top_cls));
        case ($urandom_range(0, 5))
            0:       size = $urandom;
            1:       size = 0;
            2:       size = $urandom_range(1, 64);
            default: size = chunk_tbl[$urandom_range(0, top_cls)] + $urandom_range(0, 2) - 1;
        endcase
        send_request(kind, size, cls, $urandom);
    endtask

    task automatic test_before_init();
        send_request(sca_pkg::REQ_LOOKUP, 0, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 5, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
        send_request(sca_pkg::REQ_FREE, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        send_request(sca_pkg::REQ_INIT, 0, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 1, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 16, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 17, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 131072, 0, 0);
        send_request(sca_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, top_cls, 0);
        send_request(sca_pkg::REQ_FREE, 0, 0, 32'hFFFF_FFFF);
        send_request(sca_pkg::REQ_FREE, 0, 0, 32'h0000_0000);
        send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
        send_request(sca_pkg::REQ_ALLOC, 0, 6'h3F, 0);
        send_request(sca_pkg::REQ_FREE, 0, 6'h3F, 32'h1234_5678);
        send_request(sca_pkg::REQ_FREE, 0, 1, 32'hA5A5_A5A5);
        send_request(sca_pkg::REQ_INIT, 0, 0, 0);     // re-init empties stacks
        send_request(sca_pkg::REQ_ALLOC, 0, 1, 0);
    endtask

    task automatic test_config_sweep();
        bit [31:0] cfg [5][4] = '{
            '{32'd0,          32'd81920,  32'd16,   32'd131072},
            '{32'd40000,      32'd65536,  32'd8,    32'd4096},   // class limit reached
            '{32'hFFFF_FFFF,  32'd262144, 32'd4096, 32'd131072},
            '{32'd200000,     32'd100000, 32'd100,  32'd65536},
            '{32'd1,          32'd70000,  32'd4096, 32'd4096}    // single class
        };
        for (int p = 0; p < 5; p++) begin
            setup(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
            repeat (220) random_request();
        end
    endtask

    task automatic test_stack_full();
        setup(0, 81920, 16, 131072);
        repeat (STACK_D + 2) send_request(sca_pkg::REQ_FREE, 0, 0, $urandom);
        repeat (4) send_request(sca_pkg::REQ_ALLOC, 0, 0, 0);
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back();
        no_idle = 1;
        setup(300000, 81920, 16, 131072);
        repeat (60) random_request();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_init();
        test_directed();
        test_config_sweep();
        test_stack_full();
        test_back_to_back();
        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d requests, %0d responses checked across several table setups",
                 requests, replies);
        $display("status counts ok/zero/nofit/bad/limit/full/overflow: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("slab_class_allocator verification clean");
        end else begin
            $display("%0d mismatches, %0d responses missing", errors, pending_q.size());
            $display("slab_class_allocator verification failed");
        end
        $finish;
    end
endmodule
